[rtl/core/dttfp_pkg.sv]
// Shared constants and types for the decimal text to fixed-point parser.
`default_nettype none
package dttfp_pkg;

   localparam int FRAC_BITS_DEF       = 24;
   localparam int MAX_DECIMAL_EXP_DEF = 40;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_POINT = 8'h2e;
   localparam logic [7:0] CH_LOW_E = 8'h65;
   localparam logic [7:0] CH_UP_E  = 8'h45;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;

   typedef enum logic [5:0] {
      PH_WS      = 6'b000001,
      PH_INT     = 6'b000010,
      PH_FRAC    = 6'b000100,
      PH_EXPSIGN = 6'b001000,
      PH_EXPDIG  = 6'b010000,
      PH_STOP    = 6'b100000
   } phase_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_char;   // parse the input character
      logic load;        // build the wide word and net exponent
      logic mul_step;    // one multiply by ten
      logic div_step;    // one 32-bit limb of a divide by ten
      logic finish;      // form the result word
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic exp_pos;     // net exponent above zero
      logic exp_neg;     // net exponent below zero
      logic fits;        // wide word within the limit
   } stat_type;

endpackage
`default_nettype wire

[rtl/core/dttfp_datapath.sv]
// Datapath: character parse registers, wide scaling register and result register.
`default_nettype none
module dttfp_datapath #(
   parameter int FRAC_BITS       = dttfp_pkg::FRAC_BITS_DEF,
   parameter int MAX_DECIMAL_EXP = dttfp_pkg::MAX_DECIMAL_EXP_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire dttfp_pkg::cmd_type cmd,
   output dttfp_pkg::stat_type    stat,
   input  wire [7:0]              char_code,
   output logic signed [63:0]     value,
   output logic                   saturated
);
   localparam int EW = 10;

   dttfp_pkg::phase_type phase_ff, phase_in;
   logic        neg_ff, neg_in;
   logic [63:0] mant_ff, mant_in;
   logic [7:0]  fdig_ff, fdig_in;
   logic        eneg_ff, eneg_in;
   logic [7:0]  emag_ff, emag_in;
   logic        ovf_ff, ovf_in;
   logic [127:0] w_ff, w_in;
   logic signed [EW-1:0] ex_ff, ex_in;
   logic        flag_ff, flag_in;
   logic [63:0] val_ff, val_in;
   logic        sat_ff, sat_in;
   logic [1:0]  lmb_ff, lmb_in;
   logic [3:0]  rem_ff, rem_in;

   logic        dig, sgn, is_e, ws;
   logic [3:0]  d;
   logic        push_ok;
   logic [67:0] mul_m;
   logic [11:0] em;
   logic [63:0] limit;
   logic        fits;
   logic signed [EW-1:0] ex_raw;
   logic [130:0] w_x10;
   logic [31:0] limb;
   logic [35:0] cur, q0, q1, q2, q3, q4, quo, rest;
   logic [127:0] w_load;

   assign dig  = (char_code >= dttfp_pkg::CH_ZERO) && (char_code <= dttfp_pkg::CH_NINE);
   assign d    = char_code[3:0];
   assign sgn  = (char_code == dttfp_pkg::CH_PLUS) || (char_code == dttfp_pkg::CH_MINUS);
   assign is_e = (char_code == dttfp_pkg::CH_LOW_E) || (char_code == dttfp_pkg::CH_UP_E);
   assign ws   = (char_code == dttfp_pkg::CH_SPACE) ||
                 ((char_code >= dttfp_pkg::CH_TAB) && (char_code <= dttfp_pkg::CH_CR));
   assign mul_m   = {4'd0, mant_ff} * 68'd10 + {64'd0, d};
   assign push_ok = (mul_m[67:64] == 4'd0);
   assign em      = {4'd0, emag_ff} * 12'd10 + {8'd0, d};
   assign limit   = neg_ff ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
   assign fits    = (w_ff[127:64] == 64'd0) && (w_ff[63:0] <= limit);
   assign w_x10   = {3'd0, w_ff} * 131'd10;
   assign w_load  = {64'd0, mant_ff} << FRAC_BITS;

   // Long division by ten, one 32-bit limb per cycle from the top limb down.
   // The quotient comes from a shift-and-add reciprocal with one correction.
   always_comb begin
      limb = w_ff[{lmb_ff, 5'd0} +: 32];
      cur  = {rem_ff, limb};
      q0   = (cur >> 1) + (cur >> 2);
      q1   = q0 + (q0 >> 4);
      q2   = q1 + (q1 >> 8);
      q3   = q2 + (q2 >> 16);
      q4   = q3 + (q3 >> 32);
      quo  = q4 >> 3;
      rest = cur - ((quo << 3) + (quo << 1));
      if (rest > 36'd9) begin
         quo  = quo + 36'd1;
         rest = rest - 36'd10;
      end
   end

   always_comb begin
      ex_raw = (eneg_ff ? -$signed({2'b00, emag_ff}) : $signed({2'b00, emag_ff}))
               - $signed({2'b00, fdig_ff});
   end

   always_comb begin
      phase_in = phase_ff; neg_in = neg_ff; mant_in = mant_ff; fdig_in = fdig_ff;
      eneg_in = eneg_ff; emag_in = emag_ff; ovf_in = ovf_ff;
      w_in = w_ff; ex_in = ex_ff; flag_in = flag_ff; val_in = val_ff; sat_in = sat_ff;
      lmb_in = lmb_ff; rem_in = rem_ff;
      if (cmd.take_char) begin
         case (phase_ff)
            dttfp_pkg::PH_WS, dttfp_pkg::PH_INT: begin
               if ((phase_ff == dttfp_pkg::PH_WS) && ws) begin
                  phase_in = phase_ff;
               end else if ((phase_ff == dttfp_pkg::PH_WS) && sgn) begin
                  neg_in = (char_code == dttfp_pkg::CH_MINUS);
                  phase_in = dttfp_pkg::PH_INT;
               end else if (dig) begin
                  phase_in = dttfp_pkg::PH_INT;
                  if (push_ok) mant_in = mul_m[63:0];
                  else begin
                     mant_in = '1;
                     ovf_in = 1'b1;
                  end
               end else if (char_code == dttfp_pkg::CH_POINT) phase_in = dttfp_pkg::PH_FRAC;
               else if (is_e) phase_in = dttfp_pkg::PH_EXPSIGN;
               else phase_in = dttfp_pkg::PH_STOP;
            end
            dttfp_pkg::PH_FRAC: begin
               if (dig) begin
                  if (push_ok) begin
                     mant_in = mul_m[63:0];
                     if (fdig_ff == 8'hff) ovf_in = 1'b1;
                     else fdig_in = fdig_ff + 8'd1;
                  end
               end else if (is_e) phase_in = dttfp_pkg::PH_EXPSIGN;
               else phase_in = dttfp_pkg::PH_STOP;
            end
            dttfp_pkg::PH_EXPSIGN, dttfp_pkg::PH_EXPDIG: begin
               if ((phase_ff == dttfp_pkg::PH_EXPSIGN) && sgn) begin
                  eneg_in = (char_code == dttfp_pkg::CH_MINUS);
                  phase_in = dttfp_pkg::PH_EXPDIG;
               end else if (dig) begin
                  phase_in = dttfp_pkg::PH_EXPDIG;
                  if (em > 12'd255) begin
                     emag_in = 8'hff;
                     ovf_in = 1'b1;
                  end else emag_in = em[7:0];
               end else phase_in = dttfp_pkg::PH_STOP;
            end
            default: phase_in = dttfp_pkg::PH_STOP;
         endcase
      end
      if (cmd.load) begin
         w_in = w_load;
         flag_in = ovf_ff;
         lmb_in = 2'd3;
         rem_in = 4'd0;
         if (ex_raw > EW'(MAX_DECIMAL_EXP)) begin
            ex_in = EW'(MAX_DECIMAL_EXP);
            flag_in = 1'b1;
         end else if (ex_raw < -EW'(MAX_DECIMAL_EXP)) begin
            ex_in = -EW'(MAX_DECIMAL_EXP);
            flag_in = 1'b1;
         end else ex_in = ex_raw;
      end
      if (cmd.mul_step) begin
         if (!fits) begin
            // Already past the limit: further scaling cannot bring it back.
            ex_in = '0;
            w_in = '1;
         end else begin
            w_in = w_x10[127:0];
            ex_in = ex_ff - EW'(1);
         end
      end
      if (cmd.div_step) begin
         w_in[{lmb_ff, 5'd0} +: 32] = quo[31:0];
         // The exponent moves only once the lowest limb has been divided.
         if (lmb_ff == 2'd0) begin
            ex_in = ex_ff + EW'(1);
            lmb_in = 2'd3;
            rem_in = 4'd0;
         end else begin
            lmb_in = lmb_ff - 2'd1;
            rem_in = rest[3:0];
         end
      end
      if (cmd.finish) begin
         if (fits) begin
            val_in = neg_ff ? (64'd0 - w_ff[63:0]) : w_ff[63:0];
            sat_in = flag_ff;
         end else begin
            val_in = neg_ff ? (64'd0 - limit) : limit;
            sat_in = 1'b1;
         end
         phase_in = dttfp_pkg::PH_WS; neg_in = 1'b0; mant_in = '0; fdig_in = '0;
         eneg_in = 1'b0; emag_in = '0; ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dttfp_pkg::PH_WS;
         neg_ff <= 1'b0; mant_ff <= '0; fdig_ff <= '0;
         eneg_ff <= 1'b0; emag_ff <= '0; ovf_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         neg_ff <= neg_in; mant_ff <= mant_in; fdig_ff <= fdig_in;
         eneg_ff <= eneg_in; emag_ff <= emag_in; ovf_ff <= ovf_in;
      end
      w_ff <= w_in; ex_ff <= ex_in; flag_ff <= flag_in;
      val_ff <= val_in; sat_ff <= sat_in;
      lmb_ff <= lmb_in; rem_ff <= rem_in;
   end

   assign stat.exp_pos = (ex_ff > EW'(0));
   assign stat.exp_neg = (ex_ff < EW'(0));
   assign stat.fits    = fits;
   assign value     = val_ff;
   assign saturated = sat_ff;

`ifndef SYNTHESIS
   a_ex_range: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.load) |-> (ex_ff <= EW'(MAX_DECIMAL_EXP)) && (ex_ff >= -EW'(MAX_DECIMAL_EXP)))
      else $error("net exponent out of clamp range");
   a_fdig: assert property (@(posedge clock) disable iff (reset)
      (fdig_ff != 8'd0) |-> !(phase_ff == dttfp_pkg::PH_WS))
      else $error("fraction digits counted before the number");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.finish) && !$past(reset) |-> (mant_ff == 64'd0) && !ovf_ff)
      else $error("parse state not cleared after result");
`endif
endmodule
`default_nettype wire

[rtl/core/dttfp_ctrl.sv]
// Controller: sequences character parsing, power-of-ten scaling and result handoff.
`default_nettype none
module dttfp_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire                     req_last_char,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output dttfp_pkg::cmd_type      cmd,
   input  wire dttfp_pkg::stat_type stat
);
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_LOAD  = 5'b00010,
      ST_SCALE = 5'b00100,
      ST_FIN   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic acc;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign acc = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.take_char = acc;
            if (acc && req_last_char) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (stat.exp_pos) cmd.mul_step = 1'b1;
            else if (stat.exp_neg) cmd.div_step = 1'b1;
            else state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

`ifndef SYNTHESIS
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot0(cmd))
      else $error("more than one datapath command");
   a_out: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.finish) |-> rsp_valid)
      else $error("result not presented after finish");
   a_noacc: assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("input taken while result pending");
`endif
endmodule
`default_nettype wire

[rtl/core/decimal_text_to_fixed_point_top.sv]
// Top level of the decimal text to fixed-point parser.
//  channel | ports                                   | direction
//  request | req_valid req_ready req_char_code req_last_char | in
//  response| rsp_valid rsp_ready rsp_value rsp_saturated     | out
// A character that is not last is taken only while idle. The last one adds a load
// step, one multiply by ten or one divide by ten (a step per 32-bit limb) per unit
// of the clamped net exponent (up to MAX_DECIMAL_EXP; a multiply past the limit ends
// early), a step to leave scaling and a finish step, then holds the word until taken.
// Reset is synchronous and returns the parser to the leading white space phase.
`default_nettype none
module decimal_text_to_fixed_point_top #(
   parameter int FRAC_BITS       = dttfp_pkg::FRAC_BITS_DEF,
   parameter int MAX_DECIMAL_EXP = dttfp_pkg::MAX_DECIMAL_EXP_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire [7:0]         req_char_code,
   input  wire               req_last_char,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output logic signed [63:0] rsp_value,
   output logic              rsp_saturated
);
   dttfp_pkg::cmd_type  cmd;
   dttfp_pkg::stat_type stat;

   dttfp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_last_char,
      .rsp_valid, .rsp_ready, .cmd, .stat
   );

   dttfp_datapath #(.FRAC_BITS(FRAC_BITS), .MAX_DECIMAL_EXP(MAX_DECIMAL_EXP)) u_dp (
      .clock, .reset, .cmd, .stat, .char_code(req_char_code),
      .value(rsp_value), .saturated(rsp_saturated)
   );
endmodule
`default_nettype wire
